### hdl/pse_pkg.sv
// Shared types, codes and widths for the prime sieve engine.
package pse_pkg;

	localparam int IDX_W   = 12;
	localparam int VAL_W   = 13;
	localparam int CNT_W   = 13;
	localparam int IDX_MAX = 4095;

	localparam logic [1:0] ACT_BUILD = 2'd0;
	localparam logic [1:0] ACT_PRIME = 2'd1;
	localparam logic [1:0] ACT_NEXT  = 2'd2;
	localparam logic [1:0] ACT_BELOW = 2'd3;

	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_NOT_BUILT = 2'd1;
	localparam logic [1:0] STS_RANGE     = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_QUERY,
		ST_CLEAR,
		ST_SIEVE_RD,
		ST_SIEVE_CHK,
		ST_MARK,
		ST_PROBE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic start;
		logic query;
		logic clr_wr;
		logic sieve_rd;
		logic sieve_chk;
		logic mark_wr;
		logic probe;
		logic scan;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic is_build;
		logic q_early;
		logic q_probe;
		logic clr_last;
		logic sieve_end;
		logic sieve_prime;
		logic mark_go;
		logic mark_last;
		logic scan_hit;
		logic scan_idle;
		logic out_free;
	} status_t;

endpackage

### hdl/pse_req_if.sv
// Request channel: action and value words with valid/ready.
interface pse_req_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 action;
	logic [pse_pkg::VAL_W-1:0]  value;

	modport source (output valid, action, value, input ready);
	modport sink (input valid, action, value, output ready);
endinterface

### hdl/pse_rsp_if.sv
// Response channel: result words with valid/ready.
interface pse_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 status;
	logic                       is_prime;
	logic                       found;
	logic [pse_pkg::IDX_W-1:0]  prime_value;
	logic [pse_pkg::CNT_W-1:0]  prime_count;

	modport source (output valid, status, is_prime, found, prime_value, prime_count,
		input ready);
	modport sink (input valid, status, is_prime, found, prime_value, prime_count,
		output ready);
endinterface

### hdl/pse_ctrl.sv
// Controller state machine sequencing build, probe and scan operations.
module pse_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             ready,
	input  pse_pkg::status_t sts,
	output pse_pkg::cmd_t    cmd
);

	pse_pkg::state_t state_q;
	pse_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pse_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pse_pkg::ST_IDLE: begin
				if (req_valid) state_d = pse_pkg::ST_QUERY;
			end
			pse_pkg::ST_QUERY: begin
				if (sts.is_build) state_d = pse_pkg::ST_CLEAR;
				else if (sts.q_early) state_d = pse_pkg::ST_FINISH;
				else if (sts.q_probe) state_d = pse_pkg::ST_PROBE;
				else state_d = pse_pkg::ST_SCAN;
			end
			pse_pkg::ST_CLEAR: begin
				if (sts.clr_last) state_d = pse_pkg::ST_SIEVE_RD;
			end
			pse_pkg::ST_SIEVE_RD: begin
				if (sts.sieve_end) state_d = pse_pkg::ST_FINISH;
				else state_d = pse_pkg::ST_SIEVE_CHK;
			end
			pse_pkg::ST_SIEVE_CHK: begin
				if (sts.sieve_prime && sts.mark_go) state_d = pse_pkg::ST_MARK;
				else state_d = pse_pkg::ST_SIEVE_RD;
			end
			pse_pkg::ST_MARK: begin
				if (sts.mark_last) state_d = pse_pkg::ST_SIEVE_RD;
			end
			pse_pkg::ST_PROBE: begin
				state_d = pse_pkg::ST_FINISH;
			end
			pse_pkg::ST_SCAN: begin
				if (sts.scan_hit || sts.scan_idle) state_d = pse_pkg::ST_FINISH;
			end
			pse_pkg::ST_FINISH: begin
				if (sts.out_free) state_d = pse_pkg::ST_IDLE;
			end
			default: begin
				state_d = pse_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd   = '0;
		ready = 1'b0;
		case (state_q)
			pse_pkg::ST_IDLE: begin
				ready     = 1'b1;
				cmd.start = req_valid;
			end
			pse_pkg::ST_QUERY: begin
				cmd.query = !sts.is_build;
			end
			pse_pkg::ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
			end
			pse_pkg::ST_SIEVE_RD: begin
				cmd.sieve_rd = !sts.sieve_end;
			end
			pse_pkg::ST_SIEVE_CHK: begin
				cmd.sieve_chk = 1'b1;
			end
			pse_pkg::ST_MARK: begin
				cmd.mark_wr = 1'b1;
			end
			pse_pkg::ST_PROBE: begin
				cmd.probe = 1'b1;
			end
			pse_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			pse_pkg::ST_FINISH: begin
				cmd.finish = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

`ifndef SYNTH
	a_accept_drops_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && ready) |=> !ready)
		else $error("ready held after accepting a word");

	a_finish_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("result loaded while output register is occupied");

	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");
`endif

endmodule

### hdl/pse_dp.sv
// Datapath: composite map memory, sieve and scan counters, result register.
module pse_dp #(
	parameter int MAX_N = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [pse_pkg::IDX_W-1:0]  cfg_wdata,
	input  logic [1:0]                 req_action,
	input  logic [pse_pkg::VAL_W-1:0]  req_value,
	input  pse_pkg::cmd_t              cmd,
	output pse_pkg::status_t           sts,
	pse_rsp_if.source                  rsp
);

	localparam int AW   = $clog2(MAX_N);
	localparam int LMAX = (MAX_N - 1 > pse_pkg::IDX_MAX) ? pse_pkg::IDX_MAX : MAX_N - 1;

	localparam int IW = pse_pkg::IDX_W;
	localparam int VW = pse_pkg::VAL_W;
	localparam int CW = pse_pkg::CNT_W;

	logic map_mem [0:MAX_N-1];

	logic [IW-1:0] limit_q;
	logic          built_q;
	logic          rsp_valid_q;
	logic          sv_s1;

	logic [1:0]    action_q;
	logic [VW-1:0] value_q;
	logic [VW-1:0] k_q;
	logic [VW-1:0] m_q;
	logic [VW-1:0] sk_q;
	logic [IW-1:0] si_s1;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] pval_q;
	logic          found_q;
	logic          isp_q;
	logic [1:0]    stat_q;
	logic          rdata_q;

	logic [1:0]    out_status_q;
	logic          out_isp_q;
	logic          out_found_q;
	logic [IW-1:0] out_pval_q;
	logic [CW-1:0] out_cnt_q;

	logic [IW-1:0] lim_eff;
	logic [VW-1:0] lim_w;
	logic [VW-1:0] k2;
	logic [VW:0]   m_next;
	logic          oor;
	logic          scan_dn;
	logic          issue;
	logic [VW-1:0] scan_idx;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic          mem_wdata;
	logic [AW-1:0] mem_raddr;

	assign lim_eff  = (limit_q > IW'(LMAX)) ? IW'(LMAX) : limit_q;
	assign lim_w    = {1'b0, lim_eff};
	assign k2       = {k_q[VW-2:0], 1'b0};
	assign m_next   = {1'b0, m_q} + {1'b0, k_q};
	assign scan_dn  = (action_q == pse_pkg::ACT_BELOW);
	assign oor      = scan_dn ? (value_q > lim_w + VW'(1)) : (value_q > lim_w);
	assign issue    = scan_dn ? (sk_q != '0) : (sk_q <= lim_w);
	assign scan_idx = scan_dn ? (sk_q - VW'(1)) : sk_q;

	assign sts.is_build    = (action_q == pse_pkg::ACT_BUILD);
	assign sts.q_early     = !built_q || oor;
	assign sts.q_probe     = (action_q == pse_pkg::ACT_PRIME);
	assign sts.clr_last    = (k_q == lim_w);
	assign sts.sieve_end   = (k_q > lim_w);
	assign sts.sieve_prime = !rdata_q;
	assign sts.mark_go     = (k2 <= lim_w);
	assign sts.mark_last   = (m_next > {1'b0, lim_w});
	assign sts.scan_hit    = sv_s1 && !rdata_q;
	assign sts.scan_idle   = !issue && !sv_s1;
	assign sts.out_free    = !rsp_valid_q || rsp.ready;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(k_q);
		mem_wdata = 1'b0;
		if (cmd.clr_wr) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(k_q);
			mem_wdata = (k_q < VW'(2));
		end else if (cmd.mark_wr) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(m_q);
			mem_wdata = 1'b1;
		end
	end

	always_comb begin
		if (cmd.query) mem_raddr = AW'(value_q);
		else if (cmd.scan) mem_raddr = AW'(scan_idx);
		else mem_raddr = AW'(k_q);
	end

	always_ff @(posedge clk) begin
		if (mem_we) map_mem[mem_waddr] <= mem_wdata;
		if (cmd.query || cmd.sieve_rd || cmd.scan) rdata_q <= map_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= IW'(pse_pkg::IDX_MAX);
			built_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
			sv_s1       <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
				built_q <= 1'b0;
			end else if (cmd.finish && sts.is_build) begin
				built_q <= 1'b1;
			end
			if (cmd.finish) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
			if (cmd.query) sv_s1 <= 1'b0;
			else if (cmd.scan) sv_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			action_q <= req_action;
			value_q  <= req_value;
			k_q      <= '0;
			cnt_q    <= '0;
			pval_q   <= '0;
			found_q  <= 1'b0;
			isp_q    <= 1'b0;
			stat_q   <= pse_pkg::STS_OK;
		end
		if (cmd.clr_wr) k_q <= sts.clr_last ? VW'(2) : k_q + VW'(1);
		if (cmd.sieve_chk) begin
			if (sts.sieve_prime) begin
				cnt_q   <= cnt_q + CW'(1);
				pval_q  <= k_q[IW-1:0];
				found_q <= 1'b1;
			end
			if (sts.sieve_prime && sts.mark_go) m_q <= k2;
			else k_q <= k_q + VW'(1);
		end
		if (cmd.mark_wr) begin
			m_q <= m_next[VW-1:0];
			if (sts.mark_last) k_q <= k_q + VW'(1);
		end
		if (cmd.query) begin
			if (!built_q) stat_q <= pse_pkg::STS_NOT_BUILT;
			else if (oor) stat_q <= pse_pkg::STS_RANGE;
			sk_q <= (action_q == pse_pkg::ACT_NEXT) ? value_q + VW'(1) : value_q;
		end
		if (cmd.probe) isp_q <= !rdata_q;
		if (cmd.scan) begin
			if (issue) sk_q <= scan_dn ? sk_q - VW'(1) : sk_q + VW'(1);
			si_s1 <= scan_idx[IW-1:0];
			if (sts.scan_hit) begin
				found_q <= 1'b1;
				pval_q  <= si_s1;
			end
		end
		if (cmd.finish) begin
			out_status_q <= stat_q;
			out_isp_q    <= isp_q;
			out_found_q  <= found_q;
			out_pval_q   <= pval_q;
			out_cnt_q    <= cnt_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.is_prime    = out_isp_q;
	assign rsp.found       = out_found_q;
	assign rsp.prime_value = out_pval_q;
	assign rsp.prime_count = out_cnt_q;

`ifndef SYNTH
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((cmd.clr_wr && k_q <= lim_w) || (cmd.mark_wr && m_q <= lim_w)))
		else $error("map write beyond the limit");

	a_built_after_build: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(built_q) |-> $past(cmd.finish && sts.is_build))
		else $error("built mark set without a finished build");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan && sts.scan_hit) |-> ({1'b0, si_s1} <= lim_w))
		else $error("scan hit outside the sieve");
`endif

endmodule

### hdl/prime_sieve_engine.sv
// Prime sieve engine: one request word in, one result word out, on a one-bit map memory.
// Build clears map entries 0..L, L the limit, then walks k up from 2 and marks the multiples of each prime k.
// Is-prime reads the value's map entry; next-above and largest-below walk the entries from the value
// until a prime or the end of the sieve; a not-built or out-of-range request returns its status only.
// The map memory has one write port and one read port, one access a cycle on each.
// Async reset clears control, sets limit to 4095 and marks the sieve not built; no map clear.
module prime_sieve_engine #(
	parameter int MAX_N = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [pse_pkg::IDX_W-1:0]  cfg_wdata,
	pse_req_if.sink                    req,
	pse_rsp_if.source                  rsp
);

	pse_pkg::cmd_t    cmd;
	pse_pkg::status_t sts;
	logic             rdy;

	assign req.ready = rdy;

	pse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.ready     (rdy),
		.sts       (sts),
		.cmd       (cmd)
	);

	pse_dp #(
		.MAX_N (MAX_N)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_action (req.action),
		.req_value  (req.value),
		.cmd        (cmd),
		.sts        (sts),
		.rsp        (rsp)
	);

endmodule
